// File: rtl/nps3d_pkg.sv
// ----------------------------------------------------------------------------
// nps3d_pkg
// shared widths, constants and types of the nearest point search block
// ----------------------------------------------------------------------------
package nps3d_pkg;

    localparam int COORD_BITS = 24;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int DIST_BITS  = 50;
    localparam int INDEX_BITS = 17;
    localparam int MAX_NODES  = 65536;

    // queue between the distance front and the search back
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic [DIST_BITS-1:0]         dist_t;
    typedef logic signed [DIST_BITS-1:0]  sdist_t;
    typedef logic [INDEX_BITS-1:0]        index_t;
    typedef logic [QUEUE_CW-1:0]          qcount_t;

    typedef struct packed {
        dist_t  dist_sq;
        coord_t node_x;
        coord_t node_y;
        coord_t node_z;
        logic   last_node;
    } node_beat_t;

    // queue read side as seen by the back
    typedef struct packed {
        logic       valid;
        node_beat_t beat;
    } queue_head_t;

endpackage

// File: rtl/nps3d_front.sv
// ----------------------------------------------------------------------------
// nps3d_front
// accepts node beats and works out the squared distance to the query
// ----------------------------------------------------------------------------
module nps3d_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  nps3d_pkg::coord_t   query_x,
    input  nps3d_pkg::coord_t   query_y,
    input  nps3d_pkg::coord_t   query_z,
    input  nps3d_pkg::coord_t   node_x,
    input  nps3d_pkg::coord_t   node_y,
    input  nps3d_pkg::coord_t   node_z,
    input  logic                last_node,
    input  nps3d_pkg::qcount_t  queue_count,
    output logic                push,
    output nps3d_pkg::node_beat_t push_beat
);

    typedef logic [nps3d_pkg::QUEUE_CW:0] credit_t;

    logic                 accept;
    credit_t              in_flight;

    // stage 1: axis differences
    logic                 s1_valid_reg;
    nps3d_pkg::diff_t     s1_dx_reg, s1_dy_reg, s1_dz_reg;
    nps3d_pkg::coord_t    s1_nx_reg, s1_ny_reg, s1_nz_reg;
    logic                 s1_last_reg;

    // stage 2: axis squares
    logic                 s2_valid_reg;
    nps3d_pkg::dist_t     s2_sx_reg, s2_sy_reg, s2_sz_reg;
    nps3d_pkg::coord_t    s2_nx_reg, s2_ny_reg, s2_nz_reg;
    logic                 s2_last_reg;

    // stage 3: sum
    logic                 s3_valid_reg;
    nps3d_pkg::node_beat_t s3_beat_reg;

    nps3d_pkg::sdist_t    prod_x, prod_y, prod_z;
    nps3d_pkg::dist_t     sum_next;

    // credit check: every beat in the pipe has a queue slot waiting
    assign in_flight = credit_t'(queue_count) + credit_t'(s1_valid_reg)
                     + credit_t'(s2_valid_reg) + credit_t'(s3_valid_reg);
    assign in_stall  = in_flight >= credit_t'(nps3d_pkg::QUEUE_DEPTH);
    assign accept    = in_valid && !in_stall;

    assign prod_x = nps3d_pkg::sdist_t'(s1_dx_reg) * nps3d_pkg::sdist_t'(s1_dx_reg);
    assign prod_y = nps3d_pkg::sdist_t'(s1_dy_reg) * nps3d_pkg::sdist_t'(s1_dy_reg);
    assign prod_z = nps3d_pkg::sdist_t'(s1_dz_reg) * nps3d_pkg::sdist_t'(s1_dz_reg);

    // three squares of 25-bit differences stay below 2^50, no saturation needed
    assign sum_next = s2_sx_reg + s2_sy_reg + s2_sz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_dx_reg   <= nps3d_pkg::diff_t'(query_x) - nps3d_pkg::diff_t'(node_x);
        s1_dy_reg   <= nps3d_pkg::diff_t'(query_y) - nps3d_pkg::diff_t'(node_y);
        s1_dz_reg   <= nps3d_pkg::diff_t'(query_z) - nps3d_pkg::diff_t'(node_z);
        s1_nx_reg   <= node_x;
        s1_ny_reg   <= node_y;
        s1_nz_reg   <= node_z;
        s1_last_reg <= last_node;

        s2_sx_reg   <= nps3d_pkg::dist_t'(prod_x);
        s2_sy_reg   <= nps3d_pkg::dist_t'(prod_y);
        s2_sz_reg   <= nps3d_pkg::dist_t'(prod_z);
        s2_nx_reg   <= s1_nx_reg;
        s2_ny_reg   <= s1_ny_reg;
        s2_nz_reg   <= s1_nz_reg;
        s2_last_reg <= s1_last_reg;

        s3_beat_reg.dist_sq   <= sum_next;
        s3_beat_reg.node_x    <= s2_nx_reg;
        s3_beat_reg.node_y    <= s2_ny_reg;
        s3_beat_reg.node_z    <= s2_nz_reg;
        s3_beat_reg.last_node <= s2_last_reg;
    end

    assign push      = s3_valid_reg;
    assign push_beat = s3_beat_reg;

`ifndef SYNTH
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_flight <= credit_t'(nps3d_pkg::QUEUE_DEPTH))
        else $error("front has more beats in flight than queue slots");
`endif

endmodule

// File: rtl/nps3d_queue.sv
// ----------------------------------------------------------------------------
// nps3d_queue
// short register queue between the distance front and the search back
// ----------------------------------------------------------------------------
module nps3d_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  nps3d_pkg::node_beat_t  push_beat,
    input  logic                   pop,
    output nps3d_pkg::queue_head_t head,
    output nps3d_pkg::qcount_t     count
);

    nps3d_pkg::node_beat_t              mem [nps3d_pkg::QUEUE_DEPTH];
    logic [nps3d_pkg::QUEUE_AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    nps3d_pkg::qcount_t                 count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + nps3d_pkg::qcount_t'(1);
            2'b01:   count_next = count_reg - nps3d_pkg::qcount_t'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_beat;
    end

    assign head.valid = count_reg != '0;
    assign head.beat  = mem[rd_ptr_reg];
    assign count      = count_reg;

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < nps3d_pkg::qcount_t'(nps3d_pkg::QUEUE_DEPTH)))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("queue read while empty");
`endif

endmodule

// File: rtl/nps3d_back.sv
// ----------------------------------------------------------------------------
// nps3d_back
// running best-distance search over queued beats and the result register
// ----------------------------------------------------------------------------
module nps3d_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  nps3d_pkg::dist_t       cfg_wdata,
    input  nps3d_pkg::queue_head_t head,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   found,
    output nps3d_pkg::index_t      nearest_index,
    output nps3d_pkg::coord_t      nearest_x,
    output nps3d_pkg::coord_t      nearest_y,
    output nps3d_pkg::coord_t      nearest_z
);

    nps3d_pkg::dist_t   limit_reg;
    nps3d_pkg::index_t  count_reg, count_next;
    nps3d_pkg::dist_t   best_dist_reg, best_dist_next;
    nps3d_pkg::index_t  best_pos_reg, best_pos_next;
    nps3d_pkg::coord_t  best_x_reg, best_y_reg, best_z_reg;
    nps3d_pkg::coord_t  best_x_next, best_y_next, best_z_next;

    logic               out_valid_reg, out_valid_next;
    logic               found_reg;
    nps3d_pkg::index_t  index_reg;
    nps3d_pkg::coord_t  out_x_reg, out_y_reg, out_z_reg;

    logic               start;
    logic               counting;
    logic               better;
    logic               out_free;
    nps3d_pkg::index_t  count_inc;

    assign out_free = !out_valid_reg || !out_stall;
    // a last beat needs the result register; other beats always drain
    assign pop      = head.valid && (!head.beat.last_node || out_free);

    assign start     = count_reg == '0;
    assign counting  = count_reg < nps3d_pkg::index_t'(nps3d_pkg::MAX_NODES);
    assign count_inc = count_reg + nps3d_pkg::index_t'(1);

    always_comb
    begin
        // first beat of a search starts from the limit and an empty best
        best_dist_next = start ? limit_reg : best_dist_reg;
        best_pos_next  = start ? '0 : best_pos_reg;
        best_x_next    = start ? '0 : best_x_reg;
        best_y_next    = start ? '0 : best_y_reg;
        best_z_next    = start ? '0 : best_z_reg;
        count_next     = count_reg;
        better         = 1'b0;

        if (counting)
        begin
            count_next = count_inc;
            // strict compare keeps the earlier node on a tie
            better     = head.beat.dist_sq < best_dist_next;
        end

        if (better)
        begin
            best_dist_next = head.beat.dist_sq;
            best_pos_next  = count_inc;
            best_x_next    = head.beat.node_x;
            best_y_next    = head.beat.node_y;
            best_z_next    = head.beat.node_z;
        end

        if (head.beat.last_node)
            count_next = '0;

        out_valid_next = out_valid_reg && out_stall;
        if (pop && head.beat.last_node)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= nps3d_pkg::DIST_MAX;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            if (pop)
                count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            best_dist_reg <= best_dist_next;
            best_pos_reg  <= best_pos_next;
            best_x_reg    <= best_x_next;
            best_y_reg    <= best_y_next;
            best_z_reg    <= best_z_next;
            if (head.beat.last_node)
            begin
                found_reg <= best_pos_next != '0;
                index_reg <= best_pos_next;
                out_x_reg <= best_x_next;
                out_y_reg <= best_y_next;
                out_z_reg <= best_z_next;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign nearest_index = index_reg;
    assign nearest_x     = out_x_reg;
    assign nearest_y     = out_y_reg;
    assign nearest_z     = out_z_reg;

`ifndef SYNTH
    a_found_matches_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (found_reg == (index_reg != '0)))
        else $error("found flag disagrees with nearest index");
    a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |->
            (out_x_reg == '0 && out_y_reg == '0 && out_z_reg == '0))
        else $error("result without a node carries coordinates");
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(index_reg)))
        else $error("stalled result beat changed");
`endif

endmodule

// File: rtl/nearest_point_search_3d_core.sv
// ----------------------------------------------------------------------------
// nearest_point_search_3d_core
// brute force nearest node search in 3d over squared distances
// ----------------------------------------------------------------------------
// One node beat is taken per clock, sustained, for as long as the result side
// keeps up. Each beat passes a three-stage distance pipe (difference, square,
// sum), then an eight-entry queue, then the running compare that keeps the
// best node; the result register takes the result when the last node beat
// leaves the queue. The queue slots bound the input side: in_stall rises
// when the pipe and queue together hold eight beats, which only happens while
// a finished result sits stalled on the output. The limit register applies
// from the next search start and should be written between searches.
module nearest_point_search_3d_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  nps3d_pkg::dist_t   cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  nps3d_pkg::coord_t  query_x,
    input  nps3d_pkg::coord_t  query_y,
    input  nps3d_pkg::coord_t  query_z,
    input  nps3d_pkg::coord_t  node_x,
    input  nps3d_pkg::coord_t  node_y,
    input  nps3d_pkg::coord_t  node_z,
    input  logic               last_node,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               found,
    output nps3d_pkg::index_t  nearest_index,
    output nps3d_pkg::coord_t  nearest_x,
    output nps3d_pkg::coord_t  nearest_y,
    output nps3d_pkg::coord_t  nearest_z
);

    logic                   push;
    nps3d_pkg::node_beat_t  push_beat;
    logic                   pop;
    nps3d_pkg::queue_head_t head;
    nps3d_pkg::qcount_t     queue_count;

    nps3d_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .query_x     (query_x),
        .query_y     (query_y),
        .query_z     (query_z),
        .node_x      (node_x),
        .node_y      (node_y),
        .node_z      (node_z),
        .last_node   (last_node),
        .queue_count (queue_count),
        .push        (push),
        .push_beat   (push_beat)
    );

    nps3d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_beat (push_beat),
        .pop       (pop),
        .head      (head),
        .count     (queue_count)
    );

    nps3d_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .nearest_index (nearest_index),
        .nearest_x     (nearest_x),
        .nearest_y     (nearest_y),
        .nearest_z     (nearest_z)
    );

endmodule

// File: sim/tb_nearest_point_search_3d_core.sv
// ----------------------------------------------------------------------------
// tb_nearest_point_search_3d_core
// self-checking bench for the 3d nearest node search core
// ----------------------------------------------------------------------------
// A short table of hand-made searches comes first. It covers reset and
// extreme limits, extreme coordinates, ties, a query that moves within a
// search and the strict limit boundary. Random searches follow, over several
// limit settings. Every result is checked field by field, against the table's
// expectation on checked rows and else against a running search model.
module tb_nearest_point_search_3d_core;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 1450;
    localparam int PHASE_ITEMS   = 150;
    localparam int SETTLE_CYCLES = 16;
    localparam int IDLE_PERCENT  = 18;
    localparam nps3d_pkg::coord_t C_MIN = nps3d_pkg::coord_t'(-32'sd8388608);
    localparam nps3d_pkg::coord_t C_MAX = nps3d_pkg::coord_t'(32'sd8388607);
    localparam nps3d_pkg::dist_t EXTREME_SQ = nps3d_pkg::dist_t'(64'd844424829468675);

    typedef struct packed {
        logic              found;
        nps3d_pkg::index_t index;
        nps3d_pkg::coord_t x;
        nps3d_pkg::coord_t y;
        nps3d_pkg::coord_t z;
    } nearest_t;

    typedef struct packed {
        logic              set_lim;
        nps3d_pkg::dist_t  lim;
        nps3d_pkg::coord_t qx;
        nps3d_pkg::coord_t qy;
        nps3d_pkg::coord_t qz;
        nps3d_pkg::coord_t nx;
        nps3d_pkg::coord_t ny;
        nps3d_pkg::coord_t nz;
        logic              last;
        logic              typed;
        nearest_t          want;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    nps3d_pkg::dist_t  cfg_wdata = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    nps3d_pkg::coord_t query_x = '0;
    nps3d_pkg::coord_t query_y = '0;
    nps3d_pkg::coord_t query_z = '0;
    nps3d_pkg::coord_t node_x = '0;
    nps3d_pkg::coord_t node_y = '0;
    nps3d_pkg::coord_t node_z = '0;
    logic              last_node = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              found;
    nps3d_pkg::index_t nearest_index;
    nps3d_pkg::coord_t nearest_x;
    nps3d_pkg::coord_t nearest_y;
    nps3d_pkg::coord_t nearest_z;

    // search model state
    nps3d_pkg::dist_t  limit_sq = nps3d_pkg::DIST_MAX;
    nps3d_pkg::dist_t  best_sq = '0;
    nps3d_pkg::index_t best_pos = '0;
    nps3d_pkg::coord_t best_x = '0;
    nps3d_pkg::coord_t best_y = '0;
    nps3d_pkg::coord_t best_z = '0;
    nps3d_pkg::index_t nodes_seen = '0;

    nearest_t  nearest_q[$];
    stim_row_t stim_table[$];
    int        mismatches = 0;
    int        cycles = 0;
    logic      calm = 1'b0;

    nearest_point_search_3d_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .query_x       (query_x),
        .query_y       (query_y),
        .query_z       (query_z),
        .node_x        (node_x),
        .node_y        (node_y),
        .node_z        (node_z),
        .last_node     (last_node),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .nearest_index (nearest_index),
        .nearest_x     (nearest_x),
        .nearest_y     (nearest_y),
        .nearest_z     (nearest_z)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // one node through the running compare; returns the result on the last node
    function automatic nearest_t search_node(nps3d_pkg::coord_t qx, nps3d_pkg::coord_t qy,
                                             nps3d_pkg::coord_t qz, nps3d_pkg::coord_t nx,
                                             nps3d_pkg::coord_t ny, nps3d_pkg::coord_t nz,
                                             logic last);
        longint   dx;
        longint   dy;
        longint   dz;
        longint   sum;
        nearest_t res;
        res = '0;
        if (nodes_seen == 0)
        begin
            best_sq  = limit_sq;
            best_pos = '0;
            best_x   = '0;
            best_y   = '0;
            best_z   = '0;
        end
        // past the cap nodes are not compared at all
        if (nodes_seen < nps3d_pkg::MAX_NODES)
        begin
            dx  = longint'(qx) - longint'(nx);
            dy  = longint'(qy) - longint'(ny);
            dz  = longint'(qz) - longint'(nz);
            sum = dx * dx + dy * dy + dz * dz;
            if (sum > longint'(nps3d_pkg::DIST_MAX))
                sum = longint'(nps3d_pkg::DIST_MAX);
            nodes_seen = nodes_seen + 1'b1;
            if (nps3d_pkg::dist_t'(sum) < best_sq)
            begin
                best_sq  = nps3d_pkg::dist_t'(sum);
                best_pos = nodes_seen;
                best_x   = nx;
                best_y   = ny;
                best_z   = nz;
            end
        end
        if (last)
        begin
            res.found  = (best_pos != 0);
            res.index  = best_pos;
            res.x      = best_x;
            res.y      = best_y;
            res.z      = best_z;
            nodes_seen = '0;
            best_pos   = '0;
            best_x     = '0;
            best_y     = '0;
            best_z     = '0;
        end
        return res;
    endfunction

    function automatic nps3d_pkg::coord_t near_coord(nps3d_pkg::coord_t c, int span);
        longint v;
        v = longint'(c) + longint'($urandom_range(0, 2 * span)) - span;
        if (v > longint'(C_MAX))
            v = longint'(C_MAX);
        if (v < longint'(C_MIN))
            v = longint'(C_MIN);
        return nps3d_pkg::coord_t'(v);
    endfunction

    function automatic nps3d_pkg::coord_t pick_query();
        case ($urandom_range(0, 9))
            6:       return C_MIN;
            7:       return C_MAX;
            8:       return near_coord('0, 20);
            default: return nps3d_pkg::coord_t'($urandom);
        endcase
    endfunction

    // mostly close to the query so that ties and near misses are common
    function automatic nps3d_pkg::coord_t pick_coord(nps3d_pkg::coord_t q);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return near_coord(q, 8);
            5, 6:          return nps3d_pkg::coord_t'($urandom);
            7:             return C_MIN;
            8:             return C_MAX;
            default:       return near_coord(q, 300);
        endcase
    endfunction

    task automatic add_row(input logic set_lim, input nps3d_pkg::dist_t lim,
                           input nps3d_pkg::coord_t qx, input nps3d_pkg::coord_t qy,
                           input nps3d_pkg::coord_t qz, input nps3d_pkg::coord_t nx,
                           input nps3d_pkg::coord_t ny, input nps3d_pkg::coord_t nz,
                           input logic last, input logic typed, input logic f,
                           input nps3d_pkg::index_t idx, input nps3d_pkg::coord_t wx,
                           input nps3d_pkg::coord_t wy, input nps3d_pkg::coord_t wz);
        stim_row_t r;
        r.set_lim = set_lim;
        r.lim     = lim;
        r.qx      = qx;
        r.qy      = qy;
        r.qz      = qz;
        r.nx      = nx;
        r.ny      = ny;
        r.nz      = nz;
        r.last    = last;
        r.typed   = typed;
        r.want    = '{found: f, index: idx, x: wx, y: wy, z: wz};
        stim_table = {stim_table, r};
    endtask

    task automatic send_node(input nps3d_pkg::coord_t qx, input nps3d_pkg::coord_t qy,
                             input nps3d_pkg::coord_t qz, input nps3d_pkg::coord_t nx,
                             input nps3d_pkg::coord_t ny, input nps3d_pkg::coord_t nz,
                             input logic last, input logic typed, input nearest_t want);
        nearest_t res;
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        query_x   <= qx;
        query_y   <= qy;
        query_z   <= qz;
        node_x    <= nx;
        node_y    <= ny;
        node_z    <= nz;
        last_node <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = search_node(qx, qy, qz, nx, ny, nz, last);
        if (last)
        begin
            if (typed)
                res = want;
            nearest_q = {nearest_q, res};
        end
    endtask

    // limit is only written with the block drained
    task automatic set_limit(input nps3d_pkg::dist_t value);
        in_valid <= 1'b0;
        while (nearest_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        limit_sq = value;
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want_v,
                               input logic signed [63:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        nearest_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (nearest_q.size() == 0)
            begin
                $error("result beat with nothing expected: index %0d", nearest_index);
                mismatches++;
            end
            else
            begin
                want = nearest_q.pop_front();
                check_field("found", want.found, found);
                check_field("nearest_index", want.index, nearest_index);
                check_field("nearest_x", want.x, nearest_x);
                check_field("nearest_y", want.y, nearest_y);
                check_field("nearest_z", want.z, nearest_z);
            end
        end
    end

    initial
    begin
        nps3d_pkg::coord_t qx;
        nps3d_pkg::coord_t qy;
        nps3d_pkg::coord_t qz;
        nps3d_pkg::dist_t  lim;
        int     len;
        int     phase;
        int     phase_items;
        int     random_sent;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // set  limit       query               node                 last chk  expected
        add_row(0, '0,        0, 0, 0,            5, -3, 7,            1, 1, 1, 1, 5, -3, 7);
        add_row(0, '0,        C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1, 1, 1, 1,
                C_MAX, C_MAX, C_MAX);
        add_row(0, '0,        C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 1, 1, 1, 1,
                C_MIN, C_MIN, C_MIN);
        // tie on the second node keeps the first
        add_row(0, '0,        1, 1, 1,            2, 1, 1,             0, 0, 0, 0, 0, 0, 0);
        add_row(0, '0,        1, 1, 1,            0, 1, 1,             0, 0, 0, 0, 0, 0, 0);
        add_row(0, '0,        1, 1, 1,            1, 1, 3,             1, 1, 1, 1, 2, 1, 1);
        // query moves within the search
        add_row(0, '0,        0, 0, 0,            10, 0, 0,            0, 0, 0, 0, 0, 0, 0);
        add_row(0, '0,        100, 0, 0,          99, 0, 0,            0, 0, 0, 0, 0, 0, 0);
        add_row(0, '0,        0, 0, 0,            3, 0, 0,             1, 1, 1, 2, 99, 0, 0);
        // zero limit: nothing can be found
        add_row(1, '0,        7, 7, 7,            7, 7, 7,             1, 1, 0, 0, 0, 0, 0);
        add_row(0, '0,        C_MIN, C_MAX, 0,    C_MIN, C_MAX, 0,     1, 1, 0, 0, 0, 0, 0);
        add_row(1, nps3d_pkg::dist_t'(1), 7, 7, 7, 7, 7, 7,           1, 1, 1, 1, 7, 7, 7);
        add_row(0, '0,        7, 7, 7,            8, 7, 7,             1, 1, 0, 0, 0, 0, 0);
        add_row(1, nps3d_pkg::DIST_MAX, -1, -1, -1, -100, 50, 3,      0, 0, 0, 0, 0, 0, 0);
        add_row(0, '0,        -1, -1, -1,         -2, -1, -1,          0, 0, 0, 0, 0, 0, 0);
        add_row(0, '0,        -1, -1, -1,         C_MIN, C_MAX, 0,     1, 1, 1, 2, -2, -1, -1);
        add_row(0, '0,        C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, 1, 1, 1, 1,
                C_MIN, C_MAX, C_MIN);
        // limit equal to the largest possible distance: must be strictly below
        add_row(1, EXTREME_SQ, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1, 1, 0, 0, 0, 0, 0);
        add_row(0, '0,        C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX - 1, 1, 0, 0, 0,
                0, 0, 0);

        foreach (stim_table[i])
        begin
            if (stim_table[i].set_lim)
                set_limit(stim_table[i].lim);
            send_node(stim_table[i].qx, stim_table[i].qy, stim_table[i].qz,
                      stim_table[i].nx, stim_table[i].ny, stim_table[i].nz,
                      stim_table[i].last, stim_table[i].typed, stim_table[i].want);
        end

        phase = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            case (phase % 5)
                0:       lim = nps3d_pkg::DIST_MAX;
                1:       lim = '0;
                2:       lim = nps3d_pkg::dist_t'($urandom_range(0, 200));
                3:       lim = nps3d_pkg::dist_t'({$urandom, $urandom});
                default: lim = nps3d_pkg::dist_t'($urandom_range(0, 5000));
            endcase
            set_limit(lim);
            calm = (phase == 2);

            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80)
                                                  : $urandom_range(1, 12);
                qx = pick_query();
                qy = pick_query();
                qz = pick_query();
                for (int k = 0; k < len; k++)
                begin
                    if (k != 0 && $urandom_range(0, 9) == 0)
                    begin
                        qx = pick_query();
                        qy = pick_query();
                        qz = pick_query();
                    end
                    send_node(qx, qy, qz, pick_coord(qx), pick_coord(qy), pick_coord(qz),
                              k == len - 1, 1'b0, '0);
                end
                phase_items += len;
            end
            random_sent += phase_items;
            calm = 1'b0;
            phase++;
        end

        in_valid <= 1'b0;
        while (nearest_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && nearest_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
